[hw/rtl/psm_pkg.sv]
// Shared types, codes and constants of the picture slot manager.
package psm_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int SLOT_W = 4;
  localparam int DATE_W = 48;
  localparam int REFS_W = 8;
  localparam int REQ_W = 3;
  localparam int IN_TDATA_W = 144;
  localparam int OUT_TDATA_W = 64;
  localparam logic [31:0] WINDOW_RESET = 32'd100000;

  typedef enum logic [2:0] {
    REQ_ALLOC = 3'd0,
    REQ_READY = 3'd1,
    REQ_DESTROY = 3'd2,
    REQ_LINK = 3'd3,
    REQ_UNLINK = 3'd4,
    REQ_TICK = 3'd5,
    REQ_BAD6 = 3'd6,
    REQ_BAD7 = 3'd7
  } req_t;

  typedef enum logic [2:0] {
    ST_FREE = 3'd0,
    ST_RESERVED = 3'd1,
    ST_READY = 3'd2,
    ST_DISPLAYED = 3'd3,
    ST_DESTROYED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    RC_DONE = 3'd0,
    RC_REUSED = 3'd1,
    RC_NEWFREE = 3'd2,
    RC_REPLACED = 3'd3,
    RC_NONE = 3'd4,
    RC_IDLE = 3'd5,
    RC_LATE = 3'd6,
    RC_SHOW = 3'd7
  } rc_t;

  // Classified request as it travels from the front to the back part.
  typedef struct packed {
    req_t req;
    logic bad;          // answer none without touching state
    logic [SLOT_W-1:0] slot;
    logic [1:0] fmt;
    logic [11:0] width;
    logic [11:0] height;
    logic [13:0] line_bytes;
    logic [DATE_W-1:0] date;   // picture date or current time
  } cmd_t;

  typedef struct packed {
    rc_t code;
    logic [SLOT_W-1:0] slot;
    logic [DATE_W-1:0] date;
    logic [REFS_W-1:0] refs;
  } res_t;

endpackage

[hw/rtl/picture_slot_manager_top.sv]
// Top level of the picture slot manager: stream ports, window register, front and back.
//
// The block keeps a pool of SLOTS picture slots and answers each request item
// with exactly one result item. A front part decodes requests into a two-entry
// queue; the back part works one item at a time. Allocate and tick scan the
// slot table one slot per clock (an allocation that reuses a matching slot
// stops its scan early); mark ready, destroy, link, unlink and rejected requests
// skip the scan. The result is held in an output register until taken, and the
// front keeps accepting items into its queue meanwhile while the queue has room.
// display_window sits at byte address 0 of the APB port and may be written
// only while the block is idle.
module picture_slot_manager_top import psm_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // req_type[2:0] slot[6:3] pic_format[8:7] pic_width[20:9] pic_height[32:21]
  // line_bytes[46:33] picture_date[94:47] current_time[142:95], zero bit 143
  input  logic [IN_TDATA_W-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // result_code[2:0] out_slot[6:3] out_date[54:7] out_refcount[62:55], zero bit 63
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  logic [31:0] display_window;
  logic q_valid, q_ready;
  cmd_t q_cmd;
  res_t res;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? display_window : 32'd0;

  // Write the window register on the access cycle.
  always_ff @(posedge clk) begin
    if (rst) display_window <= WINDOW_RESET;
    else if (psel && penable && pwrite && paddr == 2'd0) display_window <= pwdata;
  end

  psm_front #(.SLOTS(SLOTS)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  psm_back #(.SLOTS(SLOTS)) u_back (
    .clk(clk), .rst(rst), .window(display_window),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .res_valid(m_tvalid), .res_ready(m_tready), .res(res)
  );

  assign m_tdata = {1'b0, res.refs, res.date, res.slot, res.code};

`ifndef SYNTHESIS
  // An idle result carries no slot and no date.
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] == RC_IDLE |-> m_tdata[54:3] == '0)
    else $error("idle result with slot or date");
  // A held result stays unchanged until taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");
  // The back takes a new request only when no result is pending.
  a_one: assert property (@(posedge clk) disable iff (rst)
    q_valid && q_ready |-> !m_tvalid)
    else $error("request taken with result pending");
`endif

endmodule

[hw/rtl/psm_front.sv]
// Front part: accept request items, classify them and queue them.
module psm_front import psm_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [IN_TDATA_W-1:0] in_data,
  output logic q_valid,
  input  logic q_ready,
  output cmd_t q_cmd
);

  localparam int QD = 2;
  cmd_t fifo [QD];
  logic [0:0] wr_ptr, rd_ptr;
  logic [1:0] count;
  cmd_t cmd_in;
  logic push, pop;

  always_comb begin
    cmd_in.req = req_t'(in_data[2:0]);
    cmd_in.slot = in_data[6:3];
    cmd_in.fmt = in_data[8:7];
    cmd_in.width = in_data[20:9];
    cmd_in.height = in_data[32:21];
    cmd_in.line_bytes = in_data[46:33];
    cmd_in.date = (cmd_in.req == REQ_TICK) ? in_data[142:95] : in_data[94:47];
    case (cmd_in.req)
      REQ_ALLOC: cmd_in.bad = (in_data[8:7] == 2'd3);
      REQ_TICK:  cmd_in.bad = 1'b0;
      REQ_READY, REQ_DESTROY, REQ_LINK, REQ_UNLINK:
        cmd_in.bad = ({28'd0, in_data[6:3]} >= 32'(SLOTS));
      default:   cmd_in.bad = 1'b1;
    endcase
  end

  assign in_ready = (count != 2'(QD));
  assign push = in_valid && in_ready;
  assign q_valid = (count != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_cmd = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) fifo[wr_ptr] <= cmd_in;
  end

endmodule

[hw/rtl/psm_back.sv]
// Back part: carry out queued requests, scanning the slot table for allocate and tick, and hold the result.
module psm_back import psm_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic [31:0] window,
  input  logic q_valid,
  output logic q_ready,
  input  cmd_t q_cmd,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH, S_OUT} fsm_t;

  fsm_t state;
  status_t st [SLOTS];
  logic [1:0] s_fmt [SLOTS];
  logic [11:0] s_w [SLOTS];
  logic [11:0] s_h [SLOTS];
  logic [13:0] s_lb [SLOTS];
  logic [REFS_W-1:0] s_refs [SLOTS];
  logic [DATE_W-1:0] s_date [SLOTS];

  cmd_t cmd;
  logic [IW-1:0] idx;
  logic have_free, have_dead, have_pick;
  logic [IW-1:0] free_i, dead_i, pick_i;
  logic [DATE_W-1:0] pick_date;
  logic [IW-1:0] ts;
  logic [DATE_W:0] limit;

  assign q_ready = (state == S_IDLE);
  assign ts = IW'(cmd.slot);
  assign limit = {1'b0, cmd.date} + {17'd0, window};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
      for (int i = 0; i < SLOTS; i++) st[i] <= ST_FREE;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cmd <= q_cmd;
            idx <= '0;
            have_free <= 1'b0;
            have_dead <= 1'b0;
            have_pick <= 1'b0;
            if (q_cmd.bad || !(q_cmd.req == REQ_ALLOC || q_cmd.req == REQ_TICK))
              state <= S_FINISH;
            else state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Visit one slot per cycle.
          if (cmd.req == REQ_ALLOC) begin
            if (st[idx] == ST_DESTROYED && s_fmt[idx] == cmd.fmt &&
                s_h[idx] == cmd.height && s_lb[idx] == cmd.line_bytes) begin
              s_w[idx] <= cmd.width;
              st[idx] <= ST_RESERVED;
              res <= '{RC_REUSED, SLOT_W'(idx), '0, s_refs[idx]};
              res_valid <= 1'b1;
              state <= S_OUT;
            end else begin
              if (st[idx] == ST_DESTROYED && !have_dead) begin
                have_dead <= 1'b1;
                dead_i <= idx;
              end
              if (st[idx] == ST_FREE && !have_free) begin
                have_free <= 1'b1;
                free_i <= idx;
              end
              if (32'(idx) == 32'(SLOTS - 1)) state <= S_FINISH;
              else idx <= idx + 1'b1;
            end
          end else begin
            if (st[idx] == ST_READY && (!have_pick || s_date[idx] < pick_date)) begin
              have_pick <= 1'b1;
              pick_i <= idx;
              pick_date <= s_date[idx];
            end
            if (32'(idx) == 32'(SLOTS - 1)) state <= S_FINISH;
            else idx <= idx + 1'b1;
          end
        end
        S_FINISH: begin
          res_valid <= 1'b1;
          state <= S_OUT;
          if (cmd.bad) begin
            res <= '{RC_NONE, '0, '0, '0};
          end else begin
            case (cmd.req)
              REQ_ALLOC: begin
                if (have_free || have_dead) begin
                  s_fmt[have_free ? free_i : dead_i] <= cmd.fmt;
                  s_w[have_free ? free_i : dead_i] <= cmd.width;
                  s_h[have_free ? free_i : dead_i] <= cmd.height;
                  s_lb[have_free ? free_i : dead_i] <= cmd.line_bytes;
                  s_refs[have_free ? free_i : dead_i] <= '0;
                  st[have_free ? free_i : dead_i] <= ST_RESERVED;
                  res <= '{have_free ? RC_NEWFREE : RC_REPLACED,
                           SLOT_W'(have_free ? free_i : dead_i), '0, '0};
                end else begin
                  res <= '{RC_NONE, '0, '0, '0};
                end
              end
              REQ_TICK: begin
                if (!have_pick || {1'b0, pick_date} > limit &&
                    !(pick_date < cmd.date)) begin
                  res <= '{RC_IDLE, '0, '0, '0};
                end else begin
                  st[pick_i] <= (s_refs[pick_i] != '0) ? ST_DISPLAYED : ST_DESTROYED;
                  res <= '{(pick_date < cmd.date) ? RC_LATE : RC_SHOW,
                           SLOT_W'(pick_i), pick_date, s_refs[pick_i]};
                end
              end
              REQ_READY: begin
                st[ts] <= ST_READY;
                s_date[ts] <= cmd.date;
                res <= '{RC_DONE, cmd.slot, '0, s_refs[ts]};
              end
              REQ_DESTROY: begin
                st[ts] <= ST_DESTROYED;
                res <= '{RC_DONE, cmd.slot, '0, s_refs[ts]};
              end
              REQ_LINK: begin
                s_refs[ts] <= (s_refs[ts] == '1) ? s_refs[ts] : s_refs[ts] + 1'b1;
                res <= '{RC_DONE, cmd.slot, '0,
                         (s_refs[ts] == '1) ? s_refs[ts] : s_refs[ts] + 1'b1};
              end
              REQ_UNLINK: begin
                s_refs[ts] <= (s_refs[ts] == '0) ? '0 : s_refs[ts] - 1'b1;
                if (s_refs[ts] <= 8'd1 && st[ts] == ST_DISPLAYED)
                  st[ts] <= ST_DESTROYED;
                res <= '{RC_DONE, cmd.slot, '0,
                         (s_refs[ts] == '0) ? '0 : s_refs[ts] - 1'b1};
              end
              default: res <= '{RC_NONE, '0, '0, '0};
            endcase
          end
        end
        S_OUT: begin
          if (res_ready) begin
            res_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[sim/tb.sv]
// Testbench of the picture slot manager: random and directed requests checked against a predictor.
module tb;
  import psm_pkg::*;

  localparam int NSLOT = 16;
  localparam int LIMIT = 1000000;

  // Expected results and the slot pool as the block should see it.
  class psm_scoreboard;
    status_t slot_st[NSLOT];
    logic [1:0] slot_fmt[NSLOT];
    logic [11:0] slot_wid[NSLOT];
    logic [11:0] slot_hgt[NSLOT];
    logic [13:0] slot_lb[NSLOT];
    logic [7:0] slot_refs[NSLOT];
    logic [47:0] slot_date[NSLOT];
    bit written[NSLOT];
    logic [31:0] window;
    res_t pending[$];
    int errors;

    function new();
      for (int i = 0; i < NSLOT; i++) begin
        slot_st[i] = ST_FREE;
        written[i] = 0;
      end
      window = WINDOW_RESET;
      errors = 0;
    endfunction

    function res_t answer(rc_t code, int s, logic [47:0] d, logic [7:0] r);
      res_t x;
      x.code = code;
      x.slot = s[SLOT_W-1:0];
      x.date = d;
      x.refs = r;
      return x;
    endfunction

    function res_t allocate(logic [1:0] fmt, logic [11:0] w, logic [11:0] h,
                            logic [13:0] lb);
      int free_at;
      int dead_at;
      int s;
      rc_t code;
      free_at = -1;
      dead_at = -1;
      if (fmt == 2'd3) return answer(RC_NONE, 0, 0, 0);
      for (int i = 0; i < NSLOT; i++) begin
        if (slot_st[i] == ST_DESTROYED) begin
          if (slot_fmt[i] == fmt && slot_hgt[i] == h && slot_lb[i] == lb) begin
            slot_wid[i] = w;
            slot_st[i] = ST_RESERVED;
            return answer(RC_REUSED, i, 0, slot_refs[i]);
          end
          if (dead_at < 0) dead_at = i;
        end else if (free_at < 0 && slot_st[i] == ST_FREE) begin
          free_at = i;
        end
      end
      if (free_at >= 0) begin
        s = free_at;
        code = RC_NEWFREE;
      end else if (dead_at >= 0) begin
        s = dead_at;
        code = RC_REPLACED;
      end else begin
        return answer(RC_NONE, 0, 0, 0);
      end
      slot_fmt[s] = fmt;
      slot_wid[s] = w;
      slot_hgt[s] = h;
      slot_lb[s] = lb;
      slot_refs[s] = 0;
      slot_st[s] = ST_RESERVED;
      written[s] = 1;
      return answer(code, s, 0, 0);
    endfunction

    function res_t tick(logic [47:0] now);
      int pick;
      rc_t code;
      pick = -1;
      for (int i = 0; i < NSLOT; i++)
        if (slot_st[i] == ST_READY && (pick < 0 || slot_date[i] < slot_date[pick]))
          pick = i;
      if (pick < 0) return answer(RC_IDLE, 0, 0, 0);
      if (slot_date[pick] < now) code = RC_LATE;
      else if ({1'b0, slot_date[pick]} > {1'b0, now} + {17'd0, window})
        return answer(RC_IDLE, 0, 0, 0);
      else code = RC_SHOW;
      slot_st[pick] = (slot_refs[pick] != 0) ? ST_DISPLAYED : ST_DESTROYED;
      return answer(code, pick, slot_date[pick], slot_refs[pick]);
    endfunction

    // Predict the answer to one accepted request and queue it.
    function void note_request(logic [IN_TDATA_W-1:0] d);
      req_t req;
      int s;
      res_t r;
      req = req_t'(d[2:0]);
      s = d[6:3];
      case (req)
        REQ_ALLOC: r = allocate(d[8:7], d[20:9], d[32:21], d[46:33]);
        REQ_TICK: r = tick(d[142:95]);
        REQ_READY, REQ_DESTROY, REQ_LINK, REQ_UNLINK: begin
          if (req == REQ_READY) begin
            slot_st[s] = ST_READY;
            slot_date[s] = d[94:47];
          end else if (req == REQ_DESTROY) begin
            slot_st[s] = ST_DESTROYED;
          end else if (req == REQ_LINK) begin
            if (slot_refs[s] != 8'hFF) slot_refs[s]++;
          end else begin
            if (slot_refs[s] != 0) slot_refs[s]--;
            if (slot_refs[s] == 0 && slot_st[s] == ST_DISPLAYED) slot_st[s] = ST_DESTROYED;
          end
          r = answer(RC_DONE, s, 0, slot_refs[s]);
        end
        default: r = answer(RC_NONE, 0, 0, 0);
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] d);
      res_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, d);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (d[2:0] !== want.code || d[6:3] !== want.slot || d[54:7] !== want.date ||
          d[62:55] !== want.refs || d[63] !== 1'b0) begin
        $display("%0t: expected code %0d slot %0d date %h refs %0d, got code %0d slot %0d date %h refs %0d",
                 $time, want.code, want.slot, want.date, want.refs,
                 d[2:0], d[6:3], d[54:7], d[62:55]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  // req_type, slot, pic_format, pic_width, pic_height, line_bytes, picture_date, current_time
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  // result_code, out_slot, out_date, out_refcount, zero
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  psm_scoreboard pool = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycles = 0;
  logic [47:0] clock_now = 48'd1000;

  picture_slot_manager_top DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Hold off the result side at random.
  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

  // Check every result taken.
  always @(posedge clk) if (!rst && m_tvalid && m_tready) pool.check_result(m_tdata);

  // Give up on a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task send(input logic [IN_TDATA_W-1:0] d);
    // Idle the sender for a random share of the cycles.
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 0;
    end
    @(negedge clk);
    s_tvalid <= 1;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    pool.note_request(d);
  endtask

  // Drop valid and wait until the block has answered everything.
  task drain();
    @(negedge clk);
    s_tvalid <= 0;
    while (pool.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task write_window(input logic [31:0] v);
    @(negedge clk);
    psel <= 1;
    pwrite <= 1;
    paddr <= '0;
    pwdata <= v;
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    pool.window = v;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  // Build a request item over random filler so the unused bits toggle too, but for bit 143, which stays zero.
  function automatic logic [IN_TDATA_W-1:0] pack(req_t req, int s, logic [1:0] fmt,
      logic [11:0] w, logic [11:0] h, logic [13:0] lb, logic [47:0] pd, logic [47:0] ct);
    logic [IN_TDATA_W-1:0] d;
    logic [159:0] fill;
    fill = {$urandom, $urandom, $urandom, $urandom, $urandom};
    d = fill[IN_TDATA_W-1:0];
    d[143] = 1'b0;
    d[2:0] = req;
    d[6:3] = s[3:0];
    d[8:7] = fmt;
    d[20:9] = w;
    d[32:21] = h;
    d[46:33] = lb;
    d[94:47] = pd;
    d[142:95] = ct;
    return d;
  endfunction

  function automatic logic [47:0] rand48();
    return {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
  endfunction

  function automatic int pick_slot();
    int s;
    do s = $urandom_range(NSLOT - 1); while (!pool.written[s]);
    return s;
  endfunction

  function automatic logic [11:0] pick_height();
    case ($urandom_range(3))
      0: return 12'd0;
      1: return 12'd1080;
      2: return 12'hFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [13:0] pick_lb();
    case ($urandom_range(3))
      0: return 14'd0;
      1: return 14'd3840;
      2: return 14'h3FFF;
      default: return $urandom;
    endcase
  endfunction

  // One well-formed request with random content; a few broken ones.
  task random_item();
    int r;
    int s;
    logic [47:0] when;
    r = $urandom_range(99);
    if (r < 22) begin
      send(pack(REQ_ALLOC, $urandom, ($urandom_range(19) == 0) ? 2'd3 : $urandom_range(2),
                $urandom, pick_height(), pick_lb(), rand48(), rand48()));
    end else if (r < 40) begin
      when = ($urandom_range(9) == 0) ? rand48() : clock_now + $urandom_range(150000) - 20000;
      send(pack(REQ_READY, pick_slot(), $urandom, $urandom, $urandom, $urandom, when, rand48()));
    end else if (r < 48) begin
      send(pack(REQ_DESTROY, pick_slot(), $urandom, $urandom, $urandom, $urandom,
                rand48(), rand48()));
    end else if (r < 61) begin
      s = pick_slot();
      send(pack(REQ_LINK, s, $urandom, $urandom, $urandom, $urandom, rand48(), rand48()));
    end else if (r < 73) begin
      send(pack(REQ_UNLINK, pick_slot(), $urandom, $urandom, $urandom, $urandom,
                rand48(), rand48()));
    end else if (r < 96) begin
      clock_now = clock_now + $urandom_range(60000);
      when = ($urandom_range(15) == 0) ? rand48() : clock_now;
      send(pack(REQ_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, rand48(), when));
    end else begin
      send(pack($urandom_range(1) ? REQ_BAD6 : REQ_BAD7, $urandom, $urandom, $urandom,
                $urandom, $urandom, rand48(), rand48()));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: empty pool, rejected requests, filling every slot, overflow.
    send(pack(REQ_TICK, 0, 0, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFF));
    send(pack(REQ_BAD6, 0, 0, 0, 0, 0, 0, 0));
    send(pack(REQ_BAD7, 15, 3, 12'hFFF, 12'hFFF, 14'h3FFF, '1, '1));
    send(pack(REQ_ALLOC, 0, 2'd3, 12'd64, 12'd64, 14'd64, 0, 0));
    for (int i = 0; i < NSLOT; i++)
      send(pack(REQ_ALLOC, 0, i % 3, (i & 1) ? 12'hFFF : 12'd0, (i & 2) ? 12'hFFF : 12'd0,
                (i & 4) ? 14'h3FFF : 14'd0, 0, 0));
    send(pack(REQ_ALLOC, 0, 0, 12'd1, 12'd1, 14'd1, 0, 0));
    // Earliest date wins; one shown, one skipped late, then unlink to zero and below.
    send(pack(REQ_READY, 0, 0, 0, 0, 0, 48'd5000, 0));
    send(pack(REQ_READY, 1, 0, 0, 0, 0, 48'd4000, 0));
    send(pack(REQ_LINK, 0, 0, 0, 0, 0, 0, 0));
    send(pack(REQ_TICK, 0, 0, 0, 0, 0, 0, 48'd4000));
    send(pack(REQ_TICK, 0, 0, 0, 0, 0, 0, 48'd6000));
    send(pack(REQ_UNLINK, 0, 0, 0, 0, 0, 0, 0));
    send(pack(REQ_UNLINK, 0, 0, 0, 0, 0, 0, 0));
    // Slot 1 is destroyed with format 1, height 0, line 0: reuse it.
    send(pack(REQ_ALLOC, 0, 2'd1, 12'd77, 12'd0, 14'd0, 0, 0));
    send(pack(REQ_READY, 2, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFF, 0));
    send(pack(REQ_TICK, 0, 0, 0, 0, 0, 0, 48'd0));
    // Push one count into saturation.
    repeat (260) send(pack(REQ_LINK, 3, 0, 0, 0, 0, 0, 0));
    drain();

    // Random phases, window changed only while idle, extremes among them.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 24;
          recv_stall_pct = 79;
          write_window(32'd0);
        end
        1: begin
          send_idle_pct = 79;
          recv_stall_pct = 24;
          write_window(32'hFFFF_FFFF);
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          write_window(32'd50000);
        end
      endcase
      for (int n = 0; n < 240; n++) begin
        random_item();
        // Hold the sender until the block is fully drained.
        if (n == 120) drain();
      end
      drain();
    end

    if (pool.errors == 0 && pool.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

[files.f]
hw/rtl/psm_pkg.sv
hw/rtl/psm_front.sv
hw/rtl/psm_back.sv
hw/rtl/picture_slot_manager_top.sv
sim/tb.sv
